[src/owrs_pkg.sv]
// Shared types and constants for the 1-Wire ROM search sequencer.
`default_nettype none

package owrs_pkg;

    // ROM code geometry
    localparam int unsigned ID_BITS   = 64;
    localparam int unsigned CRC_BITS  = ID_BITS - 8;
    localparam int unsigned POS_W     = 7;
    localparam int unsigned SH_W      = 6;
    localparam logic [7:0]  CRC_POLY  = 8'h8C;

    // Request kinds carried on the input word
    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_PASS    = 2'd1,
        REQ_TRIPLET = 2'd2,
        REQ_BAD     = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_TRIPLET   = 3'd0,
        ST_FOUND     = 3'd1,
        ST_LAST      = 3'd2,
        ST_NO_PRES   = 3'd3,
        ST_BUS_ERR   = 3'd4,
        ST_CRC_ERR   = 3'd5,
        ST_FINISHED  = 3'd6
    } status_t;

    // Search phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_READY = 2'd1,
        PH_PASS  = 2'd2
    } phase_t;

endpackage

`default_nettype wire

[src/onewire_rom_search.sv]
// Top level of the 1-Wire ROM search sequencer.
`default_nettype none

// One input word is one request (start, begin pass, or triplet reply) and yields
// exactly one result word. The search state and the result register update together
// at the accepting edge, so a new word is taken every cycle while the result register
// is empty or being drained in that same cycle. The block holds the partial ROM code,
// discrepancy positions, bit position and a bit-serial CRC-8 over the first 56 bits;
// after bit 64 it reports the code found (more follow / last) or a CRC error. Both
// triplet read bits high aborts the search with a bus error.
module onewire_rom_search (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // presence, id_bit, complement_bit, dir_taken, pad
    input  wire logic [1:0]  s_tuser,   // req_type
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // direction, bit_index[6:0], rom_code[63:0]
    output logic [2:0]       m_tuser    // status
);

    localparam int unsigned PW = owrs_pkg::POS_W;
    localparam int unsigned SW = owrs_pkg::SH_W;

    // search state
    logic [owrs_pkg::ID_BITS-1:0] rom_code_reg, rom_code_next;
    logic [PW-1:0]                last_branch_reg, last_branch_next;
    logic [PW-1:0]                branch_marker_reg, branch_marker_next;
    logic [PW-1:0]                bit_position_reg, bit_position_next;
    logic [7:0]                   crc_reg, crc_next;
    owrs_pkg::phase_t             phase_reg, phase_next;

    // result register
    logic                         out_valid_reg;
    logic [2:0]                   out_status_reg, res_status;
    logic                         out_dir_reg, res_dir;
    logic [PW-1:0]                out_idx_reg, res_idx;
    logic [owrs_pkg::ID_BITS-1:0] out_code_reg, res_code;

    // unpacked input word
    owrs_pkg::req_t               req;
    logic                         presence, id_bit, complement_bit, dir_taken;
    logic                         accept;

    // triplet intermediates
    logic [PW-1:0]                pos, pos_inc;
    logic [SW-1:0]                sh;
    logic [owrs_pkg::ID_BITS-1:0] code_upd;
    logic [PW-1:0]                marker_upd;
    logic [7:0]                   crc_upd;
    logic                         last_bit, crc_ok, dir_after_pass, dir_after_trip;

    assign req            = owrs_pkg::req_t'(s_tuser);
    assign presence       = s_tdata[0];
    assign id_bit         = s_tdata[1];
    assign complement_bit = s_tdata[2];
    assign dir_taken      = s_tdata[3];

    // take a word whenever the result slot frees up this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // compute the effect of one triplet reply
    always_comb begin
        if (bit_position_reg == '0 || bit_position_reg > PW'(owrs_pkg::ID_BITS)) begin
            pos = PW'(owrs_pkg::ID_BITS);
        end else begin
            pos = bit_position_reg;
        end
        sh      = SW'(pos - PW'(1));
        pos_inc = pos + PW'(1);

        code_upd     = rom_code_reg;
        code_upd[sh] = dir_taken;

        marker_upd = (!id_bit && !complement_bit && !dir_taken) ? pos : branch_marker_reg;

        // one bit of the reflected CRC-8
        crc_upd = crc_reg;
        if (pos <= PW'(owrs_pkg::CRC_BITS)) begin
            crc_upd = {1'b0, crc_reg[7:1]} ^ ((crc_reg[0] ^ dir_taken) ? owrs_pkg::CRC_POLY
                                                                        : 8'h00);
        end

        last_bit = (pos >= PW'(owrs_pkg::ID_BITS));
        crc_ok   = (code_upd[owrs_pkg::ID_BITS-1 -: 8] == crc_upd);

        // direction for the next position: repeat below the branch, 1 at it, 0 above
        if (pos_inc < last_branch_reg) begin
            dir_after_trip = rom_code_reg[SW'(pos)];
        end else begin
            dir_after_trip = (pos_inc == last_branch_reg);
        end
        if (PW'(1) < last_branch_reg) begin
            dir_after_pass = rom_code_reg[0];
        end else begin
            dir_after_pass = (last_branch_reg == PW'(1));
        end
    end

    // next search state
    always_comb begin
        rom_code_next      = rom_code_reg;
        last_branch_next   = last_branch_reg;
        branch_marker_next = branch_marker_reg;
        bit_position_next  = bit_position_reg;
        crc_next           = crc_reg;
        phase_next         = phase_reg;
        case (req)
            owrs_pkg::REQ_START: begin
                rom_code_next      = '0;
                last_branch_next   = '0;
                branch_marker_next = '0;
                bit_position_next  = PW'(1);
                crc_next           = '0;
                phase_next         = owrs_pkg::PH_READY;
            end
            owrs_pkg::REQ_PASS: begin
                if (phase_reg != owrs_pkg::PH_IDLE) begin
                    if (!presence) begin
                        phase_next = owrs_pkg::PH_IDLE;
                    end else begin
                        phase_next         = owrs_pkg::PH_PASS;
                        bit_position_next  = PW'(1);
                        branch_marker_next = '0;
                        crc_next           = '0;
                    end
                end
            end
            owrs_pkg::REQ_TRIPLET: begin
                if (phase_reg == owrs_pkg::PH_PASS) begin
                    if (id_bit && complement_bit) begin
                        phase_next = owrs_pkg::PH_IDLE;
                    end else begin
                        rom_code_next      = code_upd;
                        branch_marker_next = marker_upd;
                        crc_next           = crc_upd;
                        if (last_bit) begin
                            last_branch_next  = marker_upd;
                            bit_position_next = PW'(1);
                            if (!crc_ok || marker_upd == '0) begin
                                phase_next = owrs_pkg::PH_IDLE;
                            end else begin
                                phase_next = owrs_pkg::PH_READY;
                            end
                        end else begin
                            bit_position_next = pos_inc;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // result word
    always_comb begin
        res_status = owrs_pkg::ST_FINISHED;
        res_dir    = 1'b0;
        res_idx    = '0;
        res_code   = '0;
        case (req)
            owrs_pkg::REQ_START: begin
                res_status = owrs_pkg::ST_TRIPLET;
            end
            owrs_pkg::REQ_PASS: begin
                if (phase_reg != owrs_pkg::PH_IDLE) begin
                    if (!presence) begin
                        res_status = owrs_pkg::ST_NO_PRES;
                    end else begin
                        res_status = owrs_pkg::ST_TRIPLET;
                        res_dir    = dir_after_pass;
                        res_idx    = PW'(1);
                    end
                end
            end
            owrs_pkg::REQ_TRIPLET: begin
                if (phase_reg == owrs_pkg::PH_PASS) begin
                    if (id_bit && complement_bit) begin
                        res_status = owrs_pkg::ST_BUS_ERR;
                    end else if (last_bit) begin
                        if (!crc_ok) begin
                            res_status = owrs_pkg::ST_CRC_ERR;
                        end else begin
                            res_status = (marker_upd == '0) ? owrs_pkg::ST_LAST
                                                            : owrs_pkg::ST_FOUND;
                            res_code   = code_upd;
                        end
                    end else begin
                        res_status = owrs_pkg::ST_TRIPLET;
                        res_dir    = dir_after_trip;
                        res_idx    = pos_inc;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // advance search state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_code_reg      <= '0;
            last_branch_reg   <= '0;
            branch_marker_reg <= '0;
            bit_position_reg  <= PW'(1);
            crc_reg           <= '0;
            phase_reg         <= owrs_pkg::PH_IDLE;
        end else if (accept) begin
            rom_code_reg      <= rom_code_next;
            last_branch_reg   <= last_branch_next;
            branch_marker_reg <= branch_marker_next;
            bit_position_reg  <= bit_position_next;
            crc_reg           <= crc_next;
            phase_reg         <= phase_next;
        end
    end

    // hold the result until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_status_reg <= res_status;
            out_dir_reg    <= res_dir;
            out_idx_reg    <= res_idx;
            out_code_reg   <= res_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_code_reg, out_idx_reg, out_dir_reg};

endmodule

`default_nettype wire

[tb/sv/onewire_rom_search_test.sv]
// Self-checking regression for the 1-Wire ROM search sequencer with a simulated device bus.
`timescale 1ns / 1ps

module onewire_rom_search_test;

    // A quiet stretch this long is a hang; the longest legal one is the receiver hold-off
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_DEV     = 8;

    typedef struct packed {
        owrs_pkg::status_t status;
        logic              direction;
        logic [6:0]        bit_index;
        logic [63:0]       rom_code;
    } search_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // presence, id_bit, complement_bit, dir_taken, pad
    logic [1:0]  s_tuser  = '0;    // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;          // direction, bit_index[6:0], rom_code[63:0]
    logic [2:0]  m_tuser;          // status

    onewire_rom_search u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Search state as the sequencer should hold it
    logic [63:0]       srch_code;
    logic [6:0]        srch_last_branch;
    logic [6:0]        srch_marker;
    logic [6:0]        srch_pos;
    logic [7:0]        srch_crc;
    owrs_pkg::phase_t  srch_phase;

    search_word_t owed_results[$];
    logic [63:0]  bus_ids[$];      // ROM codes of the devices on the simulated bus
    logic         next_dir;        // direction the sequencer asked for last

    int n_items, burst_left, mismatches;
    int n_found, n_last, n_crc, n_bus, n_nopres, n_refused, n_holds;
    int quiet, cyc, hold_left;
    bit hold_req;

    // Direction for a bit position given the previous pass
    function automatic logic steer(input logic [6:0] pos);
        if (pos < srch_last_branch) return srch_code[pos - 7'd1];
        if (pos == srch_last_branch) return 1'b1;
        return 1'b0;
    endfunction

    // Apply one request to the search state and return the word it must produce
    function automatic search_word_t advance_search(input owrs_pkg::req_t req,
                                                    input logic pres, input logic idb,
                                                    input logic cmp, input logic dtk);
        search_word_t r;
        logic [6:0]   pos;
        r.status    = owrs_pkg::ST_FINISHED;
        r.direction = 1'b0;
        r.bit_index = '0;
        r.rom_code  = '0;
        case (req)
            owrs_pkg::REQ_START: begin
                srch_code        = '0;
                srch_last_branch = '0;
                srch_marker      = '0;
                srch_pos         = 7'd1;
                srch_crc         = '0;
                srch_phase       = owrs_pkg::PH_READY;
                r.status         = owrs_pkg::ST_TRIPLET;
            end
            owrs_pkg::REQ_PASS: begin
                if (srch_phase == owrs_pkg::PH_IDLE) begin
                    r.status = owrs_pkg::ST_FINISHED;
                end else if (!pres) begin
                    srch_phase = owrs_pkg::PH_IDLE;
                    r.status   = owrs_pkg::ST_NO_PRES;
                end else begin
                    srch_phase  = owrs_pkg::PH_PASS;
                    srch_pos    = 7'd1;
                    srch_marker = '0;
                    srch_crc    = '0;
                    r.status    = owrs_pkg::ST_TRIPLET;
                    r.bit_index = 7'd1;
                    r.direction = steer(7'd1);
                end
            end
            owrs_pkg::REQ_TRIPLET: begin
                if (srch_phase != owrs_pkg::PH_PASS) begin
                    r.status = owrs_pkg::ST_FINISHED;
                end else if (idb && cmp) begin
                    srch_phase = owrs_pkg::PH_IDLE;
                    r.status   = owrs_pkg::ST_BUS_ERR;
                end else begin
                    pos = (srch_pos < 7'd1 || srch_pos > owrs_pkg::ID_BITS)
                        ? 7'(owrs_pkg::ID_BITS) : srch_pos;
                    if (!idb && !cmp && !dtk) srch_marker = pos;
                    srch_code[pos - 7'd1] = dtk;
                    // bit-serial CRC over the family code and serial number
                    if (pos <= owrs_pkg::CRC_BITS)
                        srch_crc = (srch_crc[0] ^ dtk) ? ((srch_crc >> 1) ^ owrs_pkg::CRC_POLY)
                                                       : (srch_crc >> 1);
                    if (pos >= owrs_pkg::ID_BITS) begin
                        srch_last_branch = srch_marker;
                        srch_pos         = 7'd1;
                        if (srch_code[63:56] != srch_crc) begin
                            srch_phase = owrs_pkg::PH_IDLE;
                            r.status   = owrs_pkg::ST_CRC_ERR;
                        end else if (srch_marker == 0) begin
                            srch_phase = owrs_pkg::PH_IDLE;
                            r.status   = owrs_pkg::ST_LAST;
                            r.rom_code = srch_code;
                        end else begin
                            srch_phase = owrs_pkg::PH_READY;
                            r.status   = owrs_pkg::ST_FOUND;
                            r.rom_code = srch_code;
                        end
                    end else begin
                        srch_pos    = pos + 7'd1;
                        r.status    = owrs_pkg::ST_TRIPLET;
                        r.bit_index = srch_pos;
                        r.direction = steer(srch_pos);
                    end
                end
            end
            default: r.status = owrs_pkg::ST_FINISHED;
        endcase
        return r;
    endfunction

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] dallas_crc(input logic [55:0] body);
        logic [7:0] c;
        c = '0;
        for (int i = 0; i < 56; i++)
            c = (c[0] ^ body[i]) ? ((c >> 1) ^ owrs_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    // Offer one request word, in bursts with random gaps, and log what it must produce
    task automatic send_word(input owrs_pkg::req_t req, input logic pres, input logic idb,
                             input logic cmp, input logic dtk);
        search_word_t want;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 24);
            s_tvalid <= 1'b1;
        end
        s_tuser <= req;
        s_tdata <= {4'b0000, dtk, cmp, idb, pres};
        do @(posedge aclk); while (!s_tready);
        want = advance_search(req, pres, idb, cmp, dtk);
        owed_results.push_back(want);
        next_dir = want.direction;
        n_items++;
        case (want.status)
            owrs_pkg::ST_FOUND:    n_found++;
            owrs_pkg::ST_LAST:     n_last++;
            owrs_pkg::ST_CRC_ERR:  n_crc++;
            owrs_pkg::ST_BUS_ERR:  n_bus++;
            owrs_pkg::ST_NO_PRES:  n_nopres++;
            owrs_pkg::ST_FINISHED: n_refused++;
            default: ;
        endcase
        @(negedge aclk);
        burst_left--;
        if (burst_left == 0) s_tvalid <= 1'b0;
    endtask

    // Fill the bus with devices sharing random prefixes; optionally corrupt one CRC
    task automatic build_bus(input int count, input bit bad_crc);
        logic [55:0] base, body, mask;
        logic [63:0] r, code;
        int          bad_idx, p;
        bus_ids.delete();
        r       = {$urandom, $urandom};
        base    = r[55:0];
        bad_idx = bad_crc ? $urandom_range(0, count - 1) : -1;
        for (int k = 0; k < count; k++) begin
            r    = {$urandom, $urandom};
            p    = $urandom_range(0, 55);
            mask = (56'd1 << p) - 56'd1;
            body = (base & mask) | (r[55:0] & ~mask);
            code = {dallas_crc(body), body};
            if (k == bad_idx) code[56 + $urandom_range(0, 7)] ^= 1'b1;
            bus_ids.push_back(code);
        end
    endtask

    // Enumerate the bus the way a host would; a nonzero cut_at restarts the first
    // pass at that bit with a fresh begin-pass request
    task automatic run_search(input int cut_at);
        logic [MAX_DEV-1:0] alive, full;
        logic               present, id_and, cmp_and, dtk;
        int                 passes;
        bit                 cut;
        present = (bus_ids.size() != 0);
        full    = MAX_DEV'((9'd1 << bus_ids.size()) - 9'd1);
        send_word(owrs_pkg::REQ_START, rbit(), rbit(), rbit(), rbit());
        passes = 0;
        while (passes <= bus_ids.size() + 2) begin
            send_word(owrs_pkg::REQ_PASS, present, rbit(), rbit(), rbit());
            if (!present) return;
            alive = full;
            cut   = 0;
            for (int b = 1; b <= 64; b++) begin
                if (b == cut_at) begin
                    cut_at = 0;
                    cut    = 1;
                    break;
                end
                // wired-AND of the true and complement bits of the remaining devices
                id_and  = 1'b1;
                cmp_and = 1'b1;
                for (int d = 0; d < bus_ids.size(); d++)
                    if (alive[d]) begin
                        if (bus_ids[d][b-1]) cmp_and = 1'b0;
                        else id_and = 1'b0;
                    end
                if (id_and && cmp_and) dtk = rbit();
                else if (!id_and && !cmp_and) dtk = next_dir;
                else dtk = id_and;
                send_word(owrs_pkg::REQ_TRIPLET, rbit(), id_and, cmp_and, dtk);
                if (id_and && cmp_and) return;
                for (int d = 0; d < bus_ids.size(); d++)
                    if (bus_ids[d][b-1] != dtk) alive[d] = 1'b0;
            end
            if (!cut) begin
                passes++;
                if (srch_phase != owrs_pkg::PH_READY) return;
            end
        end
    endtask

    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_word(owrs_pkg::req_t'($urandom_range(0, 3)), rbit(), rbit(), rbit(), rbit());
    endtask

    // Requests in the wrong phase, aborts, restarts and the error answers
    task automatic test_directed_cases();
        send_word(owrs_pkg::REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b1);   // triplet while idle
        send_word(owrs_pkg::REQ_PASS,    1'b1, 1'b0, 1'b0, 1'b0);   // pass while idle
        send_word(owrs_pkg::REQ_BAD,     1'b1, 1'b1, 1'b1, 1'b1);
        send_word(owrs_pkg::REQ_START,   1'b0, 1'b0, 1'b0, 1'b0);
        send_word(owrs_pkg::REQ_START,   1'b1, 1'b1, 1'b1, 1'b1);   // start while ready
        send_word(owrs_pkg::REQ_PASS,    1'b0, 1'b0, 1'b0, 1'b0);   // no presence
        send_word(owrs_pkg::REQ_PASS,    1'b1, 1'b0, 1'b0, 1'b0);
        send_word(owrs_pkg::REQ_START,   1'b0, 1'b0, 1'b0, 1'b0);
        send_word(owrs_pkg::REQ_PASS,    1'b1, 1'b0, 1'b0, 1'b0);
        send_word(owrs_pkg::REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0);   // discrepancy, took 0
        send_word(owrs_pkg::REQ_TRIPLET, 1'b0, 1'b0, 1'b1, 1'b0);
        send_word(owrs_pkg::REQ_TRIPLET, 1'b0, 1'b1, 1'b0, 1'b1);
        send_word(owrs_pkg::REQ_BAD,     1'b0, 1'b0, 1'b0, 1'b0);   // ignored mid-pass
        send_word(owrs_pkg::REQ_PASS,    1'b1, 1'b1, 1'b1, 1'b1);   // restart mid-pass
        send_word(owrs_pkg::REQ_TRIPLET, 1'b1, 1'b0, 1'b0, 1'b1);
        send_word(owrs_pkg::REQ_TRIPLET, 1'b0, 1'b1, 1'b1, 1'b0);   // both read bits high
        send_word(owrs_pkg::REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b0);   // after the abort
        send_word(owrs_pkg::REQ_START,   1'b0, 1'b0, 1'b0, 1'b0);
        send_word(owrs_pkg::REQ_PASS,    1'b1, 1'b0, 1'b0, 1'b0);
        send_word(owrs_pkg::REQ_TRIPLET, 1'b0, 1'b0, 1'b0, 1'b1);
        send_word(owrs_pkg::REQ_START,   1'b0, 1'b0, 1'b0, 1'b0);   // start mid-pass
        send_word(owrs_pkg::REQ_PASS,    1'b0, 1'b1, 1'b1, 1'b1);
    endtask

    // Single devices with all-zero and all-one bodies
    task automatic test_extreme_codes();
        bus_ids.delete();
        bus_ids.push_back({dallas_crc(56'd0), 56'd0});
        run_search(0);
        bus_ids.delete();
        bus_ids.push_back({dallas_crc({56{1'b1}}), {56{1'b1}}});
        run_search(0);
    endtask

    task automatic test_crc_error();
        build_bus(1, 1'b1);
        run_search(0);
    endtask

    // Receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        hold_req = 1'b1;
        build_bus(3, 1'b0);
        run_search(0);
    endtask

    task automatic test_random_traffic();
        int first, kind;
        first = n_items;
        while (n_items - first < 600) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                build_bus($urandom_range(1, 4), $urandom_range(0, 9) == 0);
                run_search(0);
            end else if (kind < 65) begin
                build_bus($urandom_range(2, MAX_DEV), 1'b0);
                run_search($urandom_range(1, 64));
            end else if (kind < 72) begin
                bus_ids.delete();
                run_search(0);
            end else if (kind < 85) begin
                // garbled pass: random triplet replies
                send_word(owrs_pkg::REQ_START, rbit(), rbit(), rbit(), rbit());
                send_word(owrs_pkg::REQ_PASS, 1'b1, rbit(), rbit(), rbit());
                for (int i = $urandom_range(1, 10); i > 0; i--)
                    send_word(owrs_pkg::REQ_TRIPLET, rbit(), rbit(), rbit(), rbit());
            end else begin
                send_noise($urandom_range(1, 6));
            end
        end
    endtask

    // Receiver stall pattern, chosen by cyc[9:8], plus the long hold-off
    always @(negedge aclk) begin
        cyc = cyc + 1;
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
            n_holds++;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            case (cyc[9:8])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= rbit();
                2'd2:    m_tready <= (cyc[1:0] != 2'd0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Compare each result word with the oldest owed one
    always @(posedge aclk) begin
        search_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status    = owrs_pkg::status_t'(m_tuser);
            got.direction = m_tdata[0];
            got.bit_index = m_tdata[7:1];
            got.rom_code  = m_tdata[71:8];
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d dir %0b idx %0d rom %h",
                             got.status, got.direction, got.bit_index, got.rom_code);
            end else begin
                want = owed_results.pop_front();
                if (got.status !== want.status || got.direction !== want.direction ||
                    got.bit_index !== want.bit_index || got.rom_code !== want.rom_code) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d dir %0b idx %0d rom %h, %s",
                                 want.status, want.direction, want.bit_index, want.rom_code,
                                 $sformatf("got status %0d dir %0b idx %0d rom %h",
                                           got.status, got.direction, got.bit_index,
                                           got.rom_code));
                end
            end
        end
    end

    // Watchdog on cycles where no word moves on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
        else quiet = quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results owed",
                     QUIET_LIMIT, owed_results.size());
            $display("onewire_rom_search regression: fail");
            $finish;
        end
    end

    initial begin
        n_items = 0; burst_left = 0; mismatches = 0; quiet = 0; cyc = 0; hold_left = 0;
        n_found = 0; n_last = 0; n_crc = 0; n_bus = 0; n_nopres = 0; n_refused = 0;
        n_holds = 0; hold_req = 1'b0; next_dir = 1'b0;
        srch_code = '0; srch_last_branch = '0; srch_marker = '0; srch_pos = 7'd1;
        srch_crc = '0; srch_phase = owrs_pkg::PH_IDLE;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_extreme_codes();
        test_crc_error();
        test_backpressure();
        test_random_traffic();

        // drop valid unless the last burst already did
        if (burst_left != 0) s_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("covered %0d requests: %0d codes found with more, %0d last, %0d crc errors",
                 n_items, n_found, n_last, n_crc);
        $display("  %0d bus errors, %0d absent buses, %0d refused, %0d receiver hold-offs",
                 n_bus, n_nopres, n_refused, n_holds);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("onewire_rom_search regression: pass");
        end else begin
            $display("onewire_rom_search regression: fail");
        end
        $finish;
    end

endmodule
